>>> src/cvd_pkg.sv
// cvd_pkg: shared types, constants and the full-scale lookup for the
// converter-code to voltage-digits block. No dependencies.

package cvd_pkg;

   localparam int CODE_W    = 12;
   localparam int PROD_W    = 2 * CODE_W;
   localparam int DIGIT_W   = 4;
   localparam int NDIGITS   = 4;
   localparam int BCD_W     = DIGIT_W * NDIGITS;
   localparam int CHAR_W    = 6;
   localparam int DIV_STEPS = CODE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [CODE_W-1:0] MV_FULL    = 12'd3300;
   localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'h30;
   localparam logic [CHAR_W-1:0] ASCII_NINE = 6'h39;

   typedef enum logic [1:0] {
      MODE_6BIT  = 2'd0,
      MODE_8BIT  = 2'd1,
      MODE_10BIT = 2'd2,
      MODE_12BIT = 2'd3
   } res_mode_type;

   // control from the sequencer to the datapath
   typedef struct packed {
      logic load;   // capture and clamp the code
      logic mult;   // scale by 3300 and seed the divider
      logic step;   // one quotient bit and one bcd shift
      logic emit;   // result moves to the output register
   } ctrl_type;

   function automatic logic [CODE_W-1:0] full_scale(input res_mode_type mode);
      logic [CODE_W-1:0] fs;
      case (mode)
         MODE_6BIT:  fs = 12'h03F;
         MODE_8BIT:  fs = 12'h0FF;
         MODE_10BIT: fs = 12'h3FF;
         MODE_12BIT: fs = 12'hFFF;
         default:    fs = 12'hFFF;
      endcase
      return fs;
   endfunction

endpackage

>>> src/cvd_sequencer.sv
// cvd_sequencer: small state machine that steps the shared divide unit.
// Depends on cvd_pkg.

module cvd_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic               out_free,
   output logic               busy,
   output cvd_pkg::ctrl_type  ctrl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [cvd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctrl      = '0;
      busy      = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (req_fire) begin
               ctrl.load = 1'b1;
               state_in  = ST_MULT;
            end
         end
         ST_MULT: begin
            ctrl.mult = 1'b1;
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            ctrl.step = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == cvd_pkg::CNT_W'(cvd_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait here while the output register still holds an untaken result
            if (out_free) begin
               ctrl.emit = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> src/cvd_datapath.sv
// cvd_datapath: clamp, 12x12 scale multiply, and a shared restoring divide
// step whose quotient bits feed a double-dabble bcd shifter. Depends on cvd_pkg.

module cvd_datapath (
   input  logic                                clock,
   input  cvd_pkg::ctrl_type                   ctrl,
   input  cvd_pkg::res_mode_type               mode,
   input  logic [cvd_pkg::CODE_W-1:0]          adc_code,
   output logic [cvd_pkg::CODE_W-1:0]          millivolts,
   output logic [cvd_pkg::BCD_W-1:0]           bcd
);

   localparam int CW = cvd_pkg::CODE_W;
   localparam int DW = cvd_pkg::DIGIT_W;

   logic [CW-1:0]               code_ff, code_in;
   logic [CW-1:0]               rem_ff, rem_in;
   logic [CW-1:0]               low_ff, low_in;
   logic [cvd_pkg::BCD_W-1:0]   bcd_ff, bcd_in;

   logic [CW-1:0]               fs;
   logic [cvd_pkg::PROD_W-1:0]  prod;
   logic [CW:0]                 trial;
   logic [CW:0]                 diff;
   logic                        qbit;
   logic [cvd_pkg::BCD_W-1:0]   bcd_adj;

   assign fs   = cvd_pkg::full_scale(mode);
   assign prod = cvd_pkg::PROD_W'(code_ff) * cvd_pkg::PROD_W'(cvd_pkg::MV_FULL);

   // shared compare-subtract: next remainder bit comes from the low half
   assign trial = {rem_ff, low_ff[CW-1]};
   assign diff  = trial - {1'b0, fs};
   assign qbit  = (trial >= {1'b0, fs});

   always_comb begin
      bcd_adj = bcd_ff;
      for (int i = 0; i < cvd_pkg::NDIGITS; i++) begin
         if (bcd_ff[i*DW +: DW] >= DW'(5)) begin
            bcd_adj[i*DW +: DW] = bcd_ff[i*DW +: DW] + DW'(3);
         end
      end
   end

   always_comb begin
      code_in = code_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      bcd_in  = bcd_ff;
      if (ctrl.load) begin
         code_in = (adc_code > fs) ? fs : adc_code;
      end
      if (ctrl.mult) begin
         // high half is below full scale, so the quotient fits in 12 bits
         rem_in = prod[cvd_pkg::PROD_W-1:CW];
         low_in = prod[CW-1:0];
         bcd_in = '0;
      end
      if (ctrl.step) begin
         rem_in = qbit ? diff[CW-1:0] : trial[CW-1:0];
         low_in = {low_ff[CW-2:0], qbit};
         bcd_in = {bcd_adj[cvd_pkg::BCD_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      bcd_ff  <= bcd_in;
   end

   assign millivolts = low_ff;
   assign bcd        = bcd_ff;

endmodule

>>> src/adc_code_to_voltage_digits.sv
// adc_code_to_voltage_digits: top level with csr register, sequencer, datapath
// and output register. Depends on cvd_pkg, cvd_sequencer, cvd_datapath.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_adc_code
//  rsp     | out       | rsp_valid/rsp_stall | rsp_millivolts, rsp_*_char
//  csr     | in        | csr_valid/csr_ready | csr_data (resolution mode)
//
// a code passes from transfer to result through a multiply step, twelve
// divide/bcd steps of the shared compare-subtract unit and a hand-off step.
// a new code is not taken while the previous one is still in the sequencer.
// reset clears the mode to 6 bit and empties the output register.
// a stalled result holds the sequencer in its last step; the next code is taken
// as soon as the result sits in the output register.

module adc_code_to_voltage_digits (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cvd_pkg::CODE_W-1:0]        req_adc_code,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cvd_pkg::CODE_W-1:0]        rsp_millivolts,
   output logic [cvd_pkg::CHAR_W-1:0]        rsp_volts_char,
   output logic [cvd_pkg::CHAR_W-1:0]        rsp_tenths_char,
   output logic [cvd_pkg::CHAR_W-1:0]        rsp_hundredths_char,
   output logic [cvd_pkg::CHAR_W-1:0]        rsp_thousandths_char,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_data
);

   localparam int DW = cvd_pkg::DIGIT_W;
   localparam int CH = cvd_pkg::CHAR_W;

   cvd_pkg::res_mode_type           mode_ff, mode_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [cvd_pkg::CODE_W-1:0]      mv_ff, mv_in;
   logic [cvd_pkg::BCD_W-1:0]       digits_ff, digits_in;

   cvd_pkg::ctrl_type               ctrl;
   logic                            busy;
   logic                            req_fire;
   logic                            out_free;
   logic [cvd_pkg::CODE_W-1:0]      dp_mv;
   logic [cvd_pkg::BCD_W-1:0]       dp_bcd;

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign req_fire  = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   cvd_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .busy     (busy),
      .ctrl     (ctrl)
   );

   cvd_datapath u_dp (
      .clock      (clock),
      .ctrl       (ctrl),
      .mode       (mode_ff),
      .adc_code   (req_adc_code),
      .millivolts (dp_mv),
      .bcd        (dp_bcd)
   );

   always_comb begin
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff;
      mv_in        = mv_ff;
      digits_in    = digits_ff;
      if (csr_valid && csr_ready) begin
         mode_in = cvd_pkg::res_mode_type'(csr_data);
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         mv_in        = dp_mv;
         digits_in    = dp_bcd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= cvd_pkg::MODE_6BIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mv_ff     <= mv_in;
      digits_ff <= digits_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_millivolts       = mv_ff;
   assign rsp_volts_char       = cvd_pkg::DIGIT_BASE + CH'(digits_ff[3*DW +: DW]);
   assign rsp_tenths_char      = cvd_pkg::DIGIT_BASE + CH'(digits_ff[2*DW +: DW]);
   assign rsp_hundredths_char  = cvd_pkg::DIGIT_BASE + CH'(digits_ff[1*DW +: DW]);
   assign rsp_thousandths_char = cvd_pkg::DIGIT_BASE + CH'(digits_ff[0*DW +: DW]);

`ifndef SYNTHESIS
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> req_stall)
      else $error("sequencer not busy after input transfer");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a stalled output");

   a_mv_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_millivolts <= cvd_pkg::MV_FULL))
      else $error("millivolts above full scale");

   a_volts_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_volts_char >= cvd_pkg::DIGIT_BASE &&
                     rsp_volts_char <= cvd_pkg::ASCII_NINE))
      else $error("volts character is not a decimal digit");
`endif

endmodule
